/* design/tcw_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

	// Screen geometry
	localparam int COLUMNS = 40;
	localparam int ROWS    = 25;
	localparam int CELLS   = COLUMNS * ROWS;

	localparam int ADDR_W  = $clog2(CELLS);
	localparam int COL_W   = $clog2(COLUMNS);
	localparam int ROW_W   = $clog2(ROWS);

	// Beat field widths
	localparam int FUNC_W   = 1;
	localparam int CHAR_W   = 8;
	localparam int INDEX_W  = 10;
	localparam int CELL_W   = 16;
	localparam int OCOL_W   = 6;
	localparam int OROW_W   = 5;
	localparam int ATTR_W   = 8;

	// Index compare width: wide enough to hold CELLS itself
	localparam int IDX_X_W  = ((ADDR_W > INDEX_W) ? ADDR_W : INDEX_W) + 1;

	// Register file
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam logic [0:0] REG_TEXT_ATTR = 1'b0;
	localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;

	// Codes
	localparam logic [FUNC_W-1:0] FUNC_PUT  = 1'b0;
	localparam logic [FUNC_W-1:0] FUNC_READ = 1'b1;
	localparam logic [CHAR_W-1:0] NEWLINE   = 8'h0a;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_SCROLL,
		ST_SCROLL_END
	} tcw_state_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [CELL_W-1:0] wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} tcw_ram_req_t;

endpackage

`default_nettype wire

/* design/tcw_ifs.sv */
`timescale 1ns / 1ps
`default_nettype none

interface tcw_cmd_if;
	logic                           valid;
	logic                           ready;
	logic [tcw_pkg::FUNC_W-1:0]     func;
	logic [tcw_pkg::CHAR_W-1:0]     char_code;
	logic [tcw_pkg::INDEX_W-1:0]    cell_index;

	modport source (output valid, func, char_code, cell_index, input ready);
	modport sink   (input valid, func, char_code, cell_index, output ready);
endinterface

interface tcw_rsp_if;
	logic                           valid;
	logic                           ready;
	logic [tcw_pkg::CELL_W-1:0]     read_data;
	logic [tcw_pkg::OCOL_W-1:0]     cursor_column;
	logic [tcw_pkg::OROW_W-1:0]     cursor_row;
	logic                           scrolled;

	modport source (output valid, read_data, cursor_column, cursor_row, scrolled, input ready);
	modport sink   (input valid, read_data, cursor_column, cursor_row, scrolled, output ready);
endinterface

`default_nettype wire

/* design/text_console_writer.sv */
`timescale 1ns / 1ps
`default_nettype none

// Teletype-style writer into a 40x25 text screen of 16-bit cells
// (attribute byte over character byte), held in one on-chip RAM.
// cmd channel: func 0 puts char_code at the cursor; func 1 reads cell_index.
// rsp channel: one beat per cmd beat, in order: cell data (zero for puts and
//   out-of-range reads), cursor after the beat, and a scroll flag.
// APB port: register 0 (byte address 0) is the attribute byte, reset 0x07.
// Flow per command:
//   put without scroll: result registered in the cycle after accept; one put
//     per cycle while rsp keeps up.
//   read: via the RAM read register, then ST_READ; no new cmd until loaded.
//   put that scrolls: ST_SCROLL walks every cell (1000) to shift every row up
//     through the single RAM read/write port pair and blank the last row.
// Reset: cursor goes to 0,0; the RAM is swept to zero, one cell a cycle, so
//   cmd.ready stays low until the sweep ends. APB writes are taken.
// Stall: result sits in an output register; in ST_IDLE a cmd beat is taken while
//   that register is empty or being drained by rsp.ready in the same cycle.

module text_console_writer (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	tcw_cmd_if.sink                                 cmd,
	tcw_rsp_if.source                               rsp,
	input  wire logic                               psel,
	input  wire logic                               penable,
	input  wire logic                               pwrite,
	input  wire logic [tcw_pkg::APB_ADDR_W-1:0]     paddr,
	input  wire logic [tcw_pkg::APB_DATA_W-1:0]     pwdata,
	output logic      [tcw_pkg::APB_DATA_W-1:0]     prdata,
	output logic                                    pready
);

	logic [tcw_pkg::ATTR_W-1:0] text_attr;
	tcw_pkg::tcw_ram_req_t      ram_req;
	logic [tcw_pkg::CELL_W-1:0] ram_rdata;

	// config register
	tcw_apb u_apb (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.text_attr (text_attr)
	);

	// sequencer: cursor, clear sweep, scroll copy, result register
	tcw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.rsp       (rsp),
		.text_attr (text_attr),
		.ram_req   (ram_req),
		.ram_rdata (ram_rdata)
	);

	// screen store, one write and one registered read per cycle
	tcw_ram #(
		.DEPTH (tcw_pkg::CELLS),
		.WIDTH (tcw_pkg::CELL_W),
		.AW    (tcw_pkg::ADDR_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_req.we),
		.waddr (ram_req.waddr),
		.wdata (ram_req.wdata),
		.re    (ram_req.re),
		.raddr (ram_req.raddr),
		.rdata (ram_rdata)
	);

endmodule

`default_nettype wire

/* design/tcw_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module tcw_ram #(
	parameter int DEPTH = 1000,
	parameter int WIDTH = 16,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

/* design/tcw_apb.sv */
`timescale 1ns / 1ps
`default_nettype none

module tcw_apb (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               psel,
	input  wire logic                               penable,
	input  wire logic                               pwrite,
	input  wire logic [tcw_pkg::APB_ADDR_W-1:0]     paddr,
	input  wire logic [tcw_pkg::APB_DATA_W-1:0]     pwdata,
	output logic      [tcw_pkg::APB_DATA_W-1:0]     prdata,
	output logic                                    pready,
	output logic      [tcw_pkg::ATTR_W-1:0]         text_attr
);

	logic [tcw_pkg::ATTR_W-1:0] attr_q;
	logic                       hit_attr;

	// word index sits above the byte offset
	assign hit_attr = (paddr[tcw_pkg::APB_ADDR_W-1 -: 1] == tcw_pkg::REG_TEXT_ATTR);
	assign pready   = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= tcw_pkg::ATTR_RESET;
		end else if (psel && penable && pwrite && pready && hit_attr) begin
			attr_q <= pwdata[tcw_pkg::ATTR_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (hit_attr) begin
			prdata = tcw_pkg::APB_DATA_W'(attr_q);
		end
	end

	assign text_attr = attr_q;

endmodule

`default_nettype wire

/* design/tcw_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module tcw_ctrl (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	tcw_cmd_if.sink                             cmd,
	tcw_rsp_if.source                           rsp,
	input  wire logic [tcw_pkg::ATTR_W-1:0]     text_attr,
	output tcw_pkg::tcw_ram_req_t               ram_req,
	input  wire logic [tcw_pkg::CELL_W-1:0]     ram_rdata
);

	localparam int AW = tcw_pkg::ADDR_W;
	localparam int CW = tcw_pkg::COL_W;
	localparam int RW = tcw_pkg::ROW_W;
	localparam int XW = tcw_pkg::IDX_X_W;

	tcw_pkg::tcw_state_t state_q, state_d;

	logic [AW-1:0] cnt_q, cnt_d;
	logic [CW-1:0] col_q, col_d;
	logic [RW-1:0] row_q, row_d;

	// result register
	logic                       ov_q;
	logic [tcw_pkg::CELL_W-1:0] o_data_q;
	logic [tcw_pkg::OCOL_W-1:0] o_col_q;
	logic [tcw_pkg::OROW_W-1:0] o_row_q;
	logic                       o_scr_q;

	// scroll copy stage: read issued in s0, write back in s1
	logic          cp_v_s1;
	logic          cp_blank_s1;
	logic [AW-1:0] cp_addr_s1;
	logic          rd_oor_s1;

	logic                       out_free;
	logic                       acc;
	logic                       out_load;
	logic [tcw_pkg::CELL_W-1:0] out_data_d;
	logic                       out_scr_d;
	logic [AW-1:0]              pos;
	logic                       wrap;
	logic                       last_row;
	logic                       do_scroll;
	logic [XW-1:0]              idx_x;
	logic                       idx_oor;

	assign out_free = !ov_q || rsp.ready;
	assign cmd.ready = (state_q == tcw_pkg::ST_IDLE) && out_free;
	assign acc = cmd.valid && cmd.ready;

	assign pos      = AW'(row_q) * AW'(tcw_pkg::COLUMNS) + AW'(col_q);
	assign wrap     = (col_q == CW'(tcw_pkg::COLUMNS - 1)) || (cmd.char_code == tcw_pkg::NEWLINE);
	assign last_row = (row_q == RW'(tcw_pkg::ROWS - 1));
	assign do_scroll = wrap && last_row;

	assign idx_x   = XW'(cmd.cell_index);
	assign idx_oor = (idx_x >= XW'(tcw_pkg::CELLS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tcw_pkg::ST_CLEAR;
			cnt_q   <= '0;
			col_q   <= '0;
			row_q   <= '0;
			ov_q    <= 1'b0;
			cp_v_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			col_q   <= col_d;
			row_q   <= row_d;
			ov_q    <= out_load ? 1'b1 : (rsp.ready ? 1'b0 : ov_q);
			cp_v_s1 <= (state_q == tcw_pkg::ST_SCROLL);
		end
	end

	always_ff @(posedge clk) begin
		cp_blank_s1 <= (cnt_q >= AW'(tcw_pkg::CELLS - tcw_pkg::COLUMNS));
		cp_addr_s1  <= cnt_q;
		if (acc) begin
			rd_oor_s1 <= idx_oor;
		end
		if (out_load) begin
			o_data_q <= out_data_d;
			o_col_q  <= tcw_pkg::OCOL_W'(col_d);
			o_row_q  <= tcw_pkg::OROW_W'(row_d);
			o_scr_q  <= out_scr_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		cnt_d      = cnt_q;
		col_d      = col_q;
		row_d      = row_q;
		out_load   = 1'b0;
		out_data_d = '0;
		out_scr_d  = 1'b0;
		ram_req    = '0;

		// copy / blank write-back during a scroll
		if (cp_v_s1) begin
			ram_req.we    = 1'b1;
			ram_req.waddr = cp_addr_s1;
			ram_req.wdata = cp_blank_s1 ? {text_attr, tcw_pkg::CHAR_W'(0)} : ram_rdata;
		end

		case (state_q)
			tcw_pkg::ST_CLEAR: begin
				ram_req.we    = 1'b1;
				ram_req.waddr = cnt_q;
				ram_req.wdata = '0;
				cnt_d         = cnt_q + AW'(1);
				if (cnt_q == AW'(tcw_pkg::CELLS - 1)) begin
					cnt_d   = '0;
					state_d = tcw_pkg::ST_IDLE;
				end
			end
			tcw_pkg::ST_IDLE: begin
				if (acc) begin
					if (cmd.func == tcw_pkg::FUNC_PUT) begin
						ram_req.we    = 1'b1;
						ram_req.waddr = pos;
						ram_req.wdata = {text_attr, cmd.char_code};
						col_d = wrap ? '0 : col_q + CW'(1);
						row_d = (wrap && !last_row) ? row_q + RW'(1) : row_q;
						if (do_scroll) begin
							cnt_d   = '0;
							state_d = tcw_pkg::ST_SCROLL;
						end else begin
							out_load = 1'b1;
						end
					end else begin
						ram_req.re    = 1'b1;
						ram_req.raddr = idx_x[AW-1:0];
						state_d       = tcw_pkg::ST_READ;
					end
				end
			end
			tcw_pkg::ST_READ: begin
				out_load   = 1'b1;
				out_data_d = rd_oor_s1 ? '0 : ram_rdata;
				state_d    = tcw_pkg::ST_IDLE;
			end
			tcw_pkg::ST_SCROLL: begin
				if (cnt_q < AW'(tcw_pkg::CELLS - tcw_pkg::COLUMNS)) begin
					ram_req.re    = 1'b1;
					ram_req.raddr = cnt_q + AW'(tcw_pkg::COLUMNS);
				end
				cnt_d = cnt_q + AW'(1);
				if (cnt_q == AW'(tcw_pkg::CELLS - 1)) begin
					cnt_d   = '0;
					state_d = tcw_pkg::ST_SCROLL_END;
				end
			end
			tcw_pkg::ST_SCROLL_END: begin
				out_load  = 1'b1;
				out_scr_d = 1'b1;
				state_d   = tcw_pkg::ST_IDLE;
			end
			default: begin
				state_d = tcw_pkg::ST_IDLE;
			end
		endcase
	end

	assign rsp.valid         = ov_q;
	assign rsp.read_data     = o_data_q;
	assign rsp.cursor_column = o_col_q;
	assign rsp.cursor_row    = o_row_q;
	assign rsp.scrolled      = o_scr_q;

	// a put that wraps off the last row must enter the scroll sweep
	a_scroll_entry: assert property (@(posedge clk) disable iff (!arst_n)
		acc && (cmd.func == tcw_pkg::FUNC_PUT) && do_scroll |=> state_q == tcw_pkg::ST_SCROLL)
		else $error("scroll not started");

	// result register is never overwritten while a beat is pending
	a_no_clobber: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> out_free)
		else $error("result overwritten");

	// copy writes land exactly one row above the read issued in the cycle before
	a_copy_addr: assert property (@(posedge clk) disable iff (!arst_n)
		cp_v_s1 && !cp_blank_s1 |-> cp_addr_s1 + AW'(tcw_pkg::COLUMNS) == $past(ram_req.raddr))
		else $error("scroll copy address skew");

	// after a scroll the cursor sits at the start of the last row
	a_scroll_cursor: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == tcw_pkg::ST_SCROLL_END |->
			(row_q == RW'(tcw_pkg::ROWS - 1)) && (col_q == '0))
		else $error("cursor not parked after scroll");

endmodule

`default_nettype wire
